[sv/jsu_pkg.sv]
// Shared types, codes and helper functions of the JSON string unescaper.
package jsu_pkg;

   localparam int JSU_OFFSET_WIDTH = 32;
   localparam int JSU_QUEUE_DEPTH  = 4;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;

   typedef enum logic [2:0] {
      MODE_START,
      MODE_IDLE,
      MODE_STR,
      MODE_ESC,
      MODE_HEX_HI,
      MODE_SUR_BSLASH,
      MODE_SUR_U,
      MODE_HEX_LO
   } mode_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE          = 4'd0,
      ERR_NO_OPEN_QUOTE = 4'd1,
      ERR_UNTERMINATED  = 4'd2,
      ERR_CONTROL_CHAR  = 4'd3,
      ERR_UNTERM_ESCAPE = 4'd4,
      ERR_BAD_ESCAPE    = 4'd5,
      ERR_TRUNC_HEX     = 4'd6,
      ERR_BAD_HEX       = 4'd7,
      ERR_MISSING_LOW   = 4'd8,
      ERR_BAD_LOW       = 4'd9,
      ERR_LONE_LOW      = 4'd10
   } err_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       source_end;
   } req_payload_type;

   typedef struct packed {
      kind_type    out_kind;
      logic [7:0]  out_byte;
      err_type     error_code;
      logic [31:0] error_offset;
      logic        last;
   } rsp_payload_type;

   // One queue entry: up to four data bytes, or one done / error result.
   typedef struct packed {
      logic [1:0]      last_index;
      kind_type        kind;
      logic [3:0][7:0] bytes;
      err_type         error_code;
      logic [31:0]     error_offset;
   } entry_type;

   typedef struct packed {
      logic [1:0]      last_index;
      logic [3:0][7:0] bytes;
   } utf8_type;

   // {valid, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // {valid, value} for the one-letter escapes
   function automatic logic [8:0] escape_decode(input logic [7:0] c);
      logic [8:0] r;
      r = '0;
      case (c)
         CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: r = {1'b1, c};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0C};
         8'h6E:   r = {1'b1, 8'h0A};
         8'h72:   r = {1'b1, 8'h0D};
         8'h74:   r = {1'b1, 8'h09};
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp < 21'h80) begin
         r.last_index = 2'd0;
         r.bytes[0]   = cp[7:0];
      end else if (cp < 21'h800) begin
         r.last_index = 2'd1;
         r.bytes[0]   = {3'b110, cp[10:6]};
         r.bytes[1]   = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         r.last_index = 2'd2;
         r.bytes[0]   = {4'b1110, cp[15:12]};
         r.bytes[1]   = {2'b10, cp[11:6]};
         r.bytes[2]   = {2'b10, cp[5:0]};
      end else begin
         r.last_index = 2'd3;
         r.bytes[0]   = {5'b11110, cp[20:18]};
         r.bytes[1]   = {2'b10, cp[17:12]};
         r.bytes[2]   = {2'b10, cp[11:6]};
         r.bytes[3]   = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

endpackage

[sv/jsu_chan_if.sv]
// Valid/ready channel interface carrying one payload beat.
interface jsu_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[sv/json_string_unescape_utf8.sv]
// Top level of the JSON string unescaper with UTF-8 output.
//
// req_chan: one beat per source byte (in_byte), or an end mark (source_end=1).
//   The block expects an opening quote, passes plain bytes, decodes the eight
//   one-letter escapes and \uXXXX (joining surrogate pairs) and ends a string
//   at the closing quote.
// rsp_chan: one beat per result: a data byte, a done mark or an error with its
//   code and byte offset. last marks the final beat caused by one req beat.
// Throughput: one req beat per cycle while the entry queue has room. A req beat yields zero to four rsp beats;
//   rsp beats leave at one per cycle from the output register while the receiver is ready.
// Path: a req beat lands in the entry queue at the edge that takes it; its
//   first rsp beat later moves from the queue head into the output register.
// The front end decodes each req beat as it is taken, without stalling; the entry queue
//   (QUEUE_DEPTH entries) decouples it from the serializer.
// A stalled receiver holds the output beat; the queue keeps filling and
//   req_chan.ready drops only when the queue is full.
// Reset (synchronous, active high) empties the queue and output register and
//   returns the decoder to the fresh state at byte offset zero.
module json_string_unescape_utf8
   import jsu_pkg::*;
#(
   parameter int OFFSET_WIDTH = JSU_OFFSET_WIDTH,
   parameter int QUEUE_DEPTH  = JSU_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   jsu_chan_if.sink   req_chan,
   jsu_chan_if.source rsp_chan
);

   logic            req_accept;
   logic            front_push;
   entry_type       front_entry;
   entry_type       head;
   logic            head_valid;
   logic            queue_full;
   logic            back_pop;
   req_payload_type req_beat;
   rsp_payload_type rsp_beat;

   // A beat is taken whenever the queue has room, so a full entry can always land.
   assign req_chan.ready   = !queue_full;
   assign req_accept       = req_chan.valid && !queue_full;
   assign req_beat         = req_chan.payload;
   assign rsp_chan.payload = rsp_beat;

   jsu_front #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req_beat (req_beat),
      .push     (front_push),
      .entry    (front_entry)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_entry (front_entry),
      .pop        (back_pop),
      .head       (head),
      .not_empty  (head_valid),
      .full       (queue_full)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (back_pop),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_beat   (rsp_beat)
   );

endmodule

[sv/jsu_front.sv]
// Front end: accepts source bytes, runs the decode state machine, builds entries.
module jsu_front
   import jsu_pkg::*;
#(
   parameter int OFFSET_WIDTH = JSU_OFFSET_WIDTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_payload_type req_beat,
   output logic            push,
   output entry_type       entry
);

   mode_type                mode_ff, mode_in;
   logic [11:0]             hex_acc_ff, hex_acc_in;
   logic [1:0]              hex_cnt_ff, hex_cnt_in;
   logic [9:0]              hi_bits_ff, hi_bits_in;
   logic [OFFSET_WIDTH-1:0] pos_ff, pos_in;

   logic [7:0]              c;
   logic [4:0]              hex_dec;
   logic [8:0]              esc_dec;
   logic [15:0]             hex_word;
   logic                    hex_last;
   logic                    word_is_hi, word_is_lo;
   logic [OFFSET_WIDTH-1:0] pos_inc;
   logic [10:0]             plane_bits;
   utf8_type                enc_single, enc_pair;
   err_type                 err_v;
   logic [OFFSET_WIDTH-1:0] off_v;

   assign c          = req_beat.in_byte;
   assign hex_dec    = hex_decode(c);
   assign esc_dec    = escape_decode(c);
   assign hex_word   = {hex_acc_ff, hex_dec[3:0]};
   assign hex_last   = (hex_cnt_ff == 2'd3);
   assign word_is_hi = (hex_word[15:10] == 6'b110110);
   assign word_is_lo = (hex_word[15:10] == 6'b110111);
   assign pos_inc    = (pos_ff == '1) ? pos_ff : pos_ff + OFFSET_WIDTH'(1);
   assign plane_bits = 11'(hi_bits_ff) + 11'd64;
   assign enc_single = utf8_encode(21'(hex_word));
   assign enc_pair   = utf8_encode({plane_bits, hex_word[9:0]});

   // next mode
   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         if (req_beat.source_end) begin
            mode_in = MODE_START;
         end else begin
            case (mode_ff)
               MODE_START, MODE_IDLE: begin
                  mode_in = (c == CHAR_QUOTE) ? MODE_STR : MODE_IDLE;
               end
               MODE_STR: begin
                  if (c == CHAR_QUOTE || c[7:5] == 3'd0) mode_in = MODE_IDLE;
                  else if (c == CHAR_BACKSLASH)          mode_in = MODE_ESC;
                  else                                   mode_in = MODE_STR;
               end
               MODE_ESC: begin
                  if (esc_dec[8])              mode_in = MODE_STR;
                  else if (c == CHAR_LOWER_U)  mode_in = MODE_HEX_HI;
                  else                         mode_in = MODE_IDLE;
               end
               MODE_HEX_HI: begin
                  if (!hex_dec[4])     mode_in = MODE_IDLE;
                  else if (!hex_last)  mode_in = MODE_HEX_HI;
                  else if (word_is_hi) mode_in = MODE_SUR_BSLASH;
                  else if (word_is_lo) mode_in = MODE_IDLE;
                  else                 mode_in = MODE_STR;
               end
               MODE_HEX_LO: begin
                  if (!hex_dec[4])     mode_in = MODE_IDLE;
                  else if (!hex_last)  mode_in = MODE_HEX_LO;
                  else if (word_is_lo) mode_in = MODE_STR;
                  else                 mode_in = MODE_IDLE;
               end
               MODE_SUR_BSLASH: begin
                  mode_in = (c == CHAR_BACKSLASH) ? MODE_SUR_U : MODE_IDLE;
               end
               MODE_SUR_U: begin
                  mode_in = (c == CHAR_LOWER_U) ? MODE_HEX_LO : MODE_IDLE;
               end
               default: mode_in = MODE_START;
            endcase
         end
      end
   end

   // outputs and datapath
   always_comb begin
      push       = 1'b0;
      entry      = '0;
      err_v      = ERR_NONE;
      off_v      = pos_ff;
      hex_acc_in = hex_acc_ff;
      hex_cnt_in = hex_cnt_ff;
      hi_bits_in = hi_bits_ff;
      pos_in     = pos_ff;
      if (accept) begin
         if (req_beat.source_end) begin
            pos_in     = '0;
            hex_acc_in = '0;
            hex_cnt_in = '0;
            hi_bits_in = '0;
            case (mode_ff)
               MODE_START:              err_v = ERR_NO_OPEN_QUOTE;
               MODE_STR:                err_v = ERR_UNTERMINATED;
               MODE_ESC:                err_v = ERR_UNTERM_ESCAPE;
               MODE_HEX_HI, MODE_HEX_LO: begin
                  err_v = ERR_TRUNC_HEX;
                  off_v = pos_ff - OFFSET_WIDTH'(hex_cnt_ff);
               end
               MODE_SUR_BSLASH:         err_v = ERR_MISSING_LOW;
               MODE_SUR_U: begin
                  err_v = ERR_MISSING_LOW;
                  off_v = pos_ff - OFFSET_WIDTH'(1);
               end
               default:                 err_v = ERR_NONE;
            endcase
         end else begin
            pos_in = pos_inc;
            case (mode_ff)
               MODE_START, MODE_IDLE: begin
                  if (c != CHAR_QUOTE) err_v = ERR_NO_OPEN_QUOTE;
               end
               MODE_STR: begin
                  if (c == CHAR_QUOTE) begin
                     push       = 1'b1;
                     entry.kind = KIND_DONE;
                  end else if (c[7:5] == 3'd0) begin
                     err_v = ERR_CONTROL_CHAR;
                  end else if (c != CHAR_BACKSLASH) begin
                     push           = 1'b1;
                     entry.bytes[0] = c;
                  end
               end
               MODE_ESC: begin
                  if (esc_dec[8]) begin
                     push           = 1'b1;
                     entry.bytes[0] = esc_dec[7:0];
                  end else if (c == CHAR_LOWER_U) begin
                     hex_acc_in = '0;
                     hex_cnt_in = '0;
                  end else begin
                     err_v = ERR_BAD_ESCAPE;
                     off_v = pos_inc;
                  end
               end
               MODE_HEX_HI, MODE_HEX_LO: begin
                  if (!hex_dec[4]) begin
                     err_v = ERR_BAD_HEX;
                  end else if (!hex_last) begin
                     hex_acc_in = {hex_acc_ff[7:0], hex_dec[3:0]};
                     hex_cnt_in = hex_cnt_ff + 2'd1;
                  end else begin
                     hex_acc_in = '0;
                     hex_cnt_in = '0;
                     if (mode_ff == MODE_HEX_LO) begin
                        if (word_is_lo) begin
                           push             = 1'b1;
                           entry.last_index = enc_pair.last_index;
                           entry.bytes      = enc_pair.bytes;
                        end else begin
                           err_v = ERR_BAD_LOW;
                           off_v = pos_inc;
                        end
                     end else if (word_is_hi) begin
                        hi_bits_in = hex_word[9:0];
                     end else if (word_is_lo) begin
                        err_v = ERR_LONE_LOW;
                        off_v = pos_inc;
                     end else begin
                        push             = 1'b1;
                        entry.last_index = enc_single.last_index;
                        entry.bytes      = enc_single.bytes;
                     end
                  end
               end
               MODE_SUR_BSLASH: begin
                  if (c != CHAR_BACKSLASH) err_v = ERR_MISSING_LOW;
               end
               MODE_SUR_U: begin
                  if (c != CHAR_LOWER_U) begin
                     err_v = ERR_MISSING_LOW;
                     off_v = pos_ff - OFFSET_WIDTH'(1);
                  end else begin
                     hex_acc_in = '0;
                     hex_cnt_in = '0;
                  end
               end
               default: err_v = ERR_NONE;
            endcase
         end
         if (err_v != ERR_NONE) begin
            push               = 1'b1;
            entry              = '0;
            entry.kind         = KIND_ERROR;
            entry.error_code   = err_v;
            entry.error_offset = 32'(off_v);
            if (!req_beat.source_end) begin
               hex_acc_in = '0;
               hex_cnt_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_START;
         hex_acc_ff <= '0;
         hex_cnt_ff <= '0;
         hi_bits_ff <= '0;
         pos_ff     <= '0;
      end else begin
         mode_ff    <= mode_in;
         hex_acc_ff <= hex_acc_in;
         hex_cnt_ff <= hex_cnt_in;
         hi_bits_ff <= hi_bits_in;
         pos_ff     <= pos_in;
      end
   end

endmodule

[sv/jsu_queue.sv]
// Short entry queue between the front end and the output serializer.
module jsu_queue
   import jsu_pkg::*;
#(
   parameter int DEPTH = JSU_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      not_empty,
   output logic      full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign head      = slots_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      if (!do_push && do_pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[sv/jsu_back.sv]
// Back end: splits queue entries into result beats held in an output register.
module jsu_back
   import jsu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  entry_type       head,
   input  logic            head_valid,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_beat
);

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_beat_ff, rsp_beat_in;
   logic [1:0]      idx_ff, idx_in;
   logic            load;
   logic            is_last;

   assign load      = !rsp_valid_ff || rsp_ready;
   assign is_last   = (idx_ff == head.last_index);
   assign pop       = load && head_valid && is_last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      idx_in       = idx_ff;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            rsp_beat_in.out_kind     = head.kind;
            rsp_beat_in.out_byte     = head.bytes[idx_ff];
            rsp_beat_in.error_code   = head.error_code;
            rsp_beat_in.error_offset = head.error_offset;
            rsp_beat_in.last         = is_last;
            idx_in                   = is_last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

endmodule
